### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the link-local address claim checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked check that also holds through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/llac_pkg.sv
// ----------------------------------------------------------------------------
// llac_pkg
// Shared types and constants of the link-local address claim block.
// ----------------------------------------------------------------------------
package llac_pkg;

  localparam int WAIT_BITS  = 17;
  localparam int MAC_W      = 48;
  localparam int ADDR_W     = 32;
  localparam int RAND_W     = 32;
  localparam int TICK_W     = 16;
  localparam int CNT_W      = 4;
  localparam int REQ_W      = 2;
  localparam int ACT_W      = 2;
  localparam int FIELD16_W  = 16;
  localparam int REM_W      = 16;
  localparam int REM_CNT_W  = $clog2(REM_W);
  localparam int SAT_W      = 33;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [ADDR_W-1:0]    LL_BASE       = 32'hA9FE0000;
  localparam logic [FIELD16_W-1:0] ARP_ETHERTYPE = 16'h0806;
  localparam logic [FIELD16_W-1:0] ARP_OP_REPLY  = 16'd2;
  localparam logic [7:0]           OCTET_MOD     = 8'd254;

  typedef logic [WAIT_BITS-1:0] wait_t;
  localparam wait_t WAIT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 2'd0,
    REQ_FRAME  = 2'd1,
    REQ_START  = 2'd2,
    REQ_CANCEL = 2'd3
  } req_e_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE     = 2'd0,
    ACT_PROBE    = 2'd1,
    ACT_ANNOUNCE = 2'd2,
    ACT_CLAIMED  = 2'd3
  } act_e_t;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PROBE    = 2'd1,
    PH_ANNOUNCE = 2'd2,
    PH_CLAIMED  = 2'd3
  } phase_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_MAC         = 3'd0,
    CFG_PROBE_TOTAL     = 3'd1,
    CFG_ANNOUNCE_TOTAL  = 3'd2,
    CFG_PROBE_MIN       = 3'd3,
    CFG_PROBE_SPAN      = 3'd4,
    CFG_ANNOUNCE_WAIT   = 3'd5,
    CFG_ANNOUNCE_GAP    = 3'd6,
    CFG_ANNOUNCE_JITTER = 3'd7
  } cfg_reg_e_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic div_start;
    logic load_wait;
    logic emit;
  } llac_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } llac_sts_t;

endpackage

### src/llac_if.sv
// ----------------------------------------------------------------------------
// llac_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface llac_in_if;
  logic                           valid;
  logic                           ready;
  logic [llac_pkg::REQ_W-1:0]     req_type;
  logic [llac_pkg::RAND_W-1:0]    rand_bits;
  logic [llac_pkg::FIELD16_W-1:0] rx_ethertype;
  logic [llac_pkg::FIELD16_W-1:0] rx_opcode;
  logic [llac_pkg::ADDR_W-1:0]    rx_target_ip;
  logic [llac_pkg::MAC_W-1:0]     rx_target_mac;

  modport source (
    output valid, req_type, rand_bits, rx_ethertype, rx_opcode, rx_target_ip, rx_target_mac,
    input  ready
  );
  modport sink (
    input  valid, req_type, rand_bits, rx_ethertype, rx_opcode, rx_target_ip, rx_target_mac,
    output ready
  );
endinterface

interface llac_out_if;
  logic                        valid;
  logic                        ready;
  logic [llac_pkg::ACT_W-1:0]  action;
  logic [llac_pkg::ADDR_W-1:0] address;
  logic                        conflict;
  logic                        busy_res;

  modport source (
    output valid, action, address, conflict, busy_res,
    input  ready
  );
  modport sink (
    input  valid, action, address, conflict, busy_res,
    output ready
  );
endinterface

### src/llac_rem.sv
// ----------------------------------------------------------------------------
// llac_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module llac_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [llac_pkg::REM_W-1:0] dividend,
  input  logic [llac_pkg::REM_W-1:0] divisor,
  output logic                       done,
  output logic [llac_pkg::REM_W-1:0] remainder
);
  import llac_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]     sh_r, sh_nxt;
  logic [REM_W-1:0]     den_r, den_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [REM_W:0]       trial;
  logic [REM_W:0]       diff;

  always_comb begin
    trial    = {rem_r, sh_r[REM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = dividend;
      den_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[REM_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, den_r}) ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cnt_nxt = cnt_r + REM_CNT_W'(1);
      if (cnt_r == REM_CNT_W'(REM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

### src/llac_ctrl.sv
// ----------------------------------------------------------------------------
// llac_ctrl
// Transaction sequencer: capture, evaluate, optional remainder, emit.
// ----------------------------------------------------------------------------
module llac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  llac_pkg::llac_sts_t sts,
  output llac_pkg::llac_cmd_t cmd
);
  import llac_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.need_div ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.div_start = sts.need_div;
      end
      ST_DIV: begin
        cmd.load_wait = sts.div_done;
      end
      ST_EMIT: begin
        cmd.emit = !out_valid_r || out_ready;
      end
      default: ;
    endcase
    out_valid_nxt = cmd.emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/llac_datapath.sv
// ----------------------------------------------------------------------------
// llac_datapath
// Config registers, claim state, gap arithmetic and the result register.
// ----------------------------------------------------------------------------
module llac_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [llac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [llac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [llac_pkg::REQ_W-1:0]      in_req_type,
  input  logic [llac_pkg::RAND_W-1:0]     in_rand_bits,
  input  logic [llac_pkg::FIELD16_W-1:0]  in_rx_ethertype,
  input  logic [llac_pkg::FIELD16_W-1:0]  in_rx_opcode,
  input  logic [llac_pkg::ADDR_W-1:0]     in_rx_target_ip,
  input  logic [llac_pkg::MAC_W-1:0]      in_rx_target_mac,
  input  llac_pkg::llac_cmd_t             cmd,
  output llac_pkg::llac_sts_t             sts,
  output logic [llac_pkg::ACT_W-1:0]      out_action,
  output logic [llac_pkg::ADDR_W-1:0]     out_address,
  output logic                            out_conflict,
  output logic                            out_busy_res
);
  import llac_pkg::*;

  typedef enum logic [2:0] {
    GAP_KEEP  = 3'd0,
    GAP_DEC   = 3'd1,
    GAP_ZERO  = 3'd2,
    GAP_AWAIT = 3'd3,
    GAP_PMIN  = 3'd4,
    GAP_PDIV  = 3'd5,
    GAP_AGAP  = 3'd6,
    GAP_ADIV  = 3'd7
  } gap_e_t;

  function automatic wait_t sat_wait(input logic [SAT_W-1:0] v);
    wait_t res;
    res = (v > SAT_W'(WAIT_MAX)) ? WAIT_MAX : v[WAIT_BITS-1:0];
    return res;
  endfunction

  function automatic logic [7:0] octet_pick(input logic [7:0] x);
    logic [7:0] m;
    m = (x >= OCTET_MOD) ? (x - OCTET_MOD) : x;
    return m + 8'd1;
  endfunction

  // configuration
  logic [MAC_W-1:0]  own_mac_r;
  logic [CNT_W-1:0]  probe_total_r, announce_total_r;
  logic [TICK_W-1:0] probe_min_r, probe_span_r, ann_wait_r, ann_gap_r, ann_jitter_r;

  // captured transaction
  req_e_t                req_r;
  logic [RAND_W-1:0]     rnd_r;
  logic [FIELD16_W-1:0]  eth_r, op_r;
  logic [ADDR_W-1:0]     tip_r;
  logic [MAC_W-1:0]      tmac_r;

  // claim state
  phase_e_t          phase_r, phase_nxt;
  logic [ADDR_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  ps_r, ps_nxt;
  logic [CNT_W-1:0]  as_r, as_nxt;
  wait_t             wait_r, wait_nxt;
  logic [TICK_W:0]   base_r, base_nxt;
  act_e_t            act_r, act_nxt;
  logic              conflict_r, conflict_nxt;

  // result register
  logic [ACT_W-1:0]  res_act_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic              res_conflict_r, res_busy_r;

  // evaluation
  logic              active, conflict_hit, restart, probe_go, ann_go;
  logic [CNT_W-1:0]  ps_base, as_base, ps_inc, as_inc;
  phase_e_t          phase_ev;
  logic [ADDR_W-1:0] cand_ev;
  logic [CNT_W-1:0]  ps_ev, as_ev;
  act_e_t            act_ev;
  gap_e_t            gap;
  logic [REM_W-1:0]  div_den;
  logic              rem_done;
  logic [REM_W-1:0]  rem_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r        <= '0;
      probe_total_r    <= CNT_W'(3);
      announce_total_r <= CNT_W'(3);
      probe_min_r      <= TICK_W'(1000);
      probe_span_r     <= TICK_W'(1000);
      ann_wait_r       <= TICK_W'(2000);
      ann_gap_r        <= TICK_W'(2000);
      ann_jitter_r     <= TICK_W'(200);
    end else if (cfg_we) begin
      case (cfg_reg_e_t'(cfg_idx))
        CFG_OWN_MAC:         own_mac_r        <= cfg_wdata[MAC_W-1:0];
        CFG_PROBE_TOTAL:     probe_total_r    <= cfg_wdata[CNT_W-1:0];
        CFG_ANNOUNCE_TOTAL:  announce_total_r <= cfg_wdata[CNT_W-1:0];
        CFG_PROBE_MIN:       probe_min_r      <= cfg_wdata[TICK_W-1:0];
        CFG_PROBE_SPAN:      probe_span_r     <= cfg_wdata[TICK_W-1:0];
        CFG_ANNOUNCE_WAIT:   ann_wait_r       <= cfg_wdata[TICK_W-1:0];
        CFG_ANNOUNCE_GAP:    ann_gap_r        <= cfg_wdata[TICK_W-1:0];
        CFG_ANNOUNCE_JITTER: ann_jitter_r     <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= req_e_t'(in_req_type);
      rnd_r  <= in_rand_bits;
      eth_r  <= in_rx_ethertype;
      op_r   <= in_rx_opcode;
      tip_r  <= in_rx_target_ip;
      tmac_r <= in_rx_target_mac;
    end
  end

  always_comb begin
    active       = (phase_r == PH_PROBE) || (phase_r == PH_ANNOUNCE);
    conflict_hit = (req_r == REQ_FRAME) && active && (eth_r == ARP_ETHERTYPE) &&
                   (op_r == ARP_OP_REPLY) && (tip_r == cand_r) && (tmac_r != own_mac_r);
    restart      = (req_r == REQ_START) || conflict_hit;
    phase_ev     = phase_r;
    cand_ev      = cand_r;
    ps_ev        = ps_r;
    as_ev        = as_r;
    act_ev       = ACT_NONE;
    gap          = GAP_KEEP;
    probe_go     = 1'b0;
    ann_go       = 1'b0;
    ps_base      = ps_r;
    as_base      = as_r;
    case (req_r)
      REQ_TICK: begin
        if (active) begin
          if (wait_r > WAIT_BITS'(1)) begin
            gap = GAP_DEC;
          end else begin
            gap = GAP_ZERO;
            if (phase_r == PH_PROBE) begin
              if (ps_r < probe_total_r) begin
                probe_go = 1'b1;
                act_ev   = ACT_PROBE;
              end else begin
                phase_ev = PH_ANNOUNCE;
                as_base  = '0;
                ann_go   = 1'b1;
                act_ev   = ACT_ANNOUNCE;
              end
            end else if (as_r < announce_total_r) begin
              ann_go = 1'b1;
              act_ev = ACT_ANNOUNCE;
            end else begin
              phase_ev = PH_CLAIMED;
              act_ev   = ACT_CLAIMED;
            end
          end
        end
      end
      REQ_FRAME, REQ_START: begin
        if (restart) begin
          cand_ev  = LL_BASE | {16'h0000, octet_pick(rnd_r[31:24]), octet_pick(rnd_r[23:16])};
          phase_ev = PH_PROBE;
          ps_base  = '0;
          as_ev    = '0;
          probe_go = 1'b1;
          act_ev   = ACT_PROBE;
        end
      end
      REQ_CANCEL: begin
        phase_ev = PH_IDLE;
        cand_ev  = '0;
        ps_ev    = '0;
        as_ev    = '0;
        gap      = GAP_ZERO;
      end
      default: ;
    endcase
    ps_inc = ps_base + CNT_W'(1);
    as_inc = as_base + CNT_W'(1);
    if (probe_go) begin
      ps_ev = ps_inc;
      if (ps_inc >= probe_total_r)          gap = GAP_AWAIT;
      else if (probe_span_r >= TICK_W'(2)) gap = GAP_PDIV;
      else                                  gap = GAP_PMIN;
    end
    if (ann_go) begin
      as_ev = as_inc;
      gap   = (ann_jitter_r != '0) ? GAP_ADIV : GAP_AGAP;
    end
    div_den = (gap == GAP_PDIV) ? (probe_span_r - TICK_W'(1)) : ann_jitter_r;
  end

  always_comb begin
    phase_nxt    = phase_r;
    cand_nxt     = cand_r;
    ps_nxt       = ps_r;
    as_nxt       = as_r;
    wait_nxt     = wait_r;
    base_nxt     = base_r;
    act_nxt      = act_r;
    conflict_nxt = conflict_r;
    if (cmd.eval) begin
      phase_nxt    = phase_ev;
      cand_nxt     = cand_ev;
      ps_nxt       = ps_ev;
      as_nxt       = as_ev;
      act_nxt      = act_ev;
      conflict_nxt = conflict_hit;
      base_nxt     = (gap == GAP_PDIV) ? ({1'b0, probe_min_r} + (TICK_W + 1)'(1))
                                       : {1'b0, ann_gap_r};
      case (gap)
        GAP_DEC:   wait_nxt = wait_r - WAIT_BITS'(1);
        GAP_ZERO:  wait_nxt = '0;
        GAP_AWAIT: wait_nxt = sat_wait(SAT_W'(ann_wait_r));
        GAP_PMIN:  wait_nxt = sat_wait(SAT_W'(probe_min_r));
        GAP_AGAP:  wait_nxt = sat_wait(SAT_W'(ann_gap_r));
        default:   wait_nxt = wait_r;
      endcase
    end else if (cmd.load_wait) begin
      wait_nxt = sat_wait(SAT_W'(base_r) + SAT_W'(rem_val));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cand_r     <= '0;
      ps_r       <= '0;
      as_r       <= '0;
      wait_r     <= '0;
      act_r      <= ACT_NONE;
      conflict_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cand_r     <= cand_nxt;
      ps_r       <= ps_nxt;
      as_r       <= as_nxt;
      wait_r     <= wait_nxt;
      act_r      <= act_nxt;
      conflict_r <= conflict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    if (cmd.emit) begin
      res_act_r      <= act_r;
      res_addr_r     <= cand_r;
      res_conflict_r <= conflict_r;
      res_busy_r     <= (phase_r == PH_PROBE) || (phase_r == PH_ANNOUNCE);
    end
  end

  llac_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rnd_r[REM_W-1:0]),
    .divisor   (div_den),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign sts.need_div  = (gap == GAP_PDIV) || (gap == GAP_ADIV);
  assign sts.div_done  = rem_done;
  assign out_action    = res_act_r;
  assign out_address   = res_addr_r;
  assign out_conflict  = res_conflict_r;
  assign out_busy_res  = res_busy_r;

endmodule

### src/link_local_address_claim.sv
// A request is captured, evaluated and handed to the result register, with a
// remainder step first when a random gap is drawn: the gap after a non-final
// probe (span >= 2) or an announcement (jitter > 0) needs a remainder of the
// low 16 random bits, from a bit-serial remainder unit one bit per cycle. A new
// request is taken while the previous result still waits in the output register.
// After reset the gap/count timers are clear and the block is ready at once.
// ----------------------------------------------------------------------------
// link_local_address_claim
// Top level: IPv4 link-local address claim sequencer.
// ----------------------------------------------------------------------------
module link_local_address_claim (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [llac_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [llac_pkg::CFG_DATA_W-1:0] cfg_wdata,
  llac_in_if.sink                         in_if,
  llac_out_if.source                      out_if
);
  import llac_pkg::*;

  llac_cmd_t cmd;
  llac_sts_t sts;

  llac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  llac_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_if.req_type),
    .in_rand_bits     (in_if.rand_bits),
    .in_rx_ethertype  (in_if.rx_ethertype),
    .in_rx_opcode     (in_if.rx_opcode),
    .in_rx_target_ip  (in_if.rx_target_ip),
    .in_rx_target_mac (in_if.rx_target_mac),
    .cmd              (cmd),
    .sts              (sts),
    .out_action       (out_if.action),
    .out_address      (out_if.address),
    .out_conflict     (out_if.conflict),
    .out_busy_res     (out_if.busy_res)
  );

endmodule

### src/llac_checker.sv
// ----------------------------------------------------------------------------
// llac_checker
// Port-level checks of the link-local address claim block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module llac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [llac_pkg::ACT_W-1:0]  out_action,
  input logic [llac_pkg::ADDR_W-1:0] out_address,
  input logic                        out_conflict,
  input logic                        out_busy_res
);
  import llac_pkg::*;

  `ASSERT_CLK_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_address))
  `ASSERT_CLK(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `ASSERT_CLK(a_probe_addr, clk, rst_n, out_valid && (out_action == ACT_PROBE) |-> out_busy_res && (out_address[31:16] == LL_BASE[31:16]))
  `ASSERT_CLK(a_conflict_probe, clk, rst_n, out_valid && out_conflict |-> out_action == ACT_PROBE)

endmodule

bind link_local_address_claim llac_checker u_llac_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_action   (out_if.action),
  .out_address  (out_if.address),
  .out_conflict (out_if.conflict),
  .out_busy_res (out_if.busy_res)
);
